### rtl/lcdseq_pkg.sv
// ----------------------------------------------------------------------------
// lcdseq_pkg
// Types, codes and constant tables shared by the character LCD sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdseq_pkg;

	localparam int unsigned ADDR_W = 4;
	localparam int unsigned DATA_W = 32;

	typedef enum logic [1:0] {
		REQ_INIT   = 2'd0,
		REQ_CMD    = 2'd1,
		REQ_DATA   = 2'd2,
		REQ_CURSOR = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		REG_PULSE    = 2'd0,
		REG_BYTE_GAP = 2'd1,
		REG_POWER_UP = 2'd2
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_PWR  = 4'b0010,
		ST_RST  = 4'b0100,
		ST_BYTE = 4'b1000
	} state_t;

	localparam logic [7:0]  PULSE_RESET    = 8'd10;
	localparam logic [9:0]  BYTE_GAP_RESET = 10'd100;
	localparam logic [15:0] POWER_UP_RESET = 16'd45000;

	localparam logic [7:0] CURSOR_BASE  = 8'h80;
	localparam logic [2:0] INIT_CMD_LAST = 3'd4;
	localparam logic [1:0] RST_NIB_LAST  = 2'd3;
	localparam logic [1:0] PHASE_LAST    = 2'd2;
	localparam logic [1:0] PHASE_HIGH    = 2'd1;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] byte_value;
		logic [1:0] line;
		logic [6:0] column;
	} req_t;

	typedef struct packed {
		logic        reg_select;
		logic        read_write;
		logic        enable_pin;
		logic [3:0]  data_nibble;
		logic [15:0] hold_us;
		logic        last;
	} pin_t;

	// controller -> datapath
	typedef struct packed {
		logic       load;
		logic       emit;
		logic       pwr;
		logic       rst;
		logic       init;
		logic [1:0] phase;
		logic [1:0] sub;
		logic [2:0] cmd_idx;
		logic       last;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;
	} dp_status_t;

	function automatic logic [7:0] init_cmd(input logic [2:0] idx);
		logic [7:0] v;
		case (idx)
			3'd0:    v = 8'h28;
			3'd1:    v = 8'h08;
			3'd2:    v = 8'h01;
			3'd3:    v = 8'h06;
			3'd4:    v = 8'h0F;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

	function automatic logic [12:0] init_wait(input logic [1:0] idx);
		logic [12:0] v;
		case (idx)
			2'd0:    v = 13'd5000;
			2'd1:    v = 13'd60;
			default: v = 13'd2000;
		endcase
		return v;
	endfunction

	function automatic logic [3:0] init_nibble(input logic [1:0] idx);
		return (idx == RST_NIB_LAST) ? 4'h2 : 4'h3;
	endfunction

endpackage

`default_nettype wire

### rtl/lcdseq_ctrl.sv
// ----------------------------------------------------------------------------
// lcdseq_ctrl
// Sequencing state machine: walks power-up, reset nibbles and byte phases.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdseq_ctrl import lcdseq_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	input  wire logic [1:0] req_type,
	output logic            req_stall,
	input  dp_status_t      status,
	output dp_cmd_t         cmd
);

	state_t     state_q;
	logic [1:0] phase_q;
	logic [1:0] sub_q;
	logic [2:0] cmd_q;
	logic       init_q;
	logic       accept;
	logic       emit;
	logic       phase_end;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && (state_q == ST_IDLE);
	assign emit      = (state_q != ST_IDLE) && status.out_free;
	assign phase_end = (phase_q == PHASE_LAST);

	always_comb begin
		cmd.load    = accept;
		cmd.emit    = emit;
		cmd.pwr     = (state_q == ST_PWR);
		cmd.rst     = (state_q == ST_RST);
		cmd.init    = init_q;
		cmd.phase   = phase_q;
		cmd.sub     = sub_q;
		cmd.cmd_idx = cmd_q;
		cmd.last    = (state_q == ST_BYTE) && phase_end && sub_q[0] &&
			(!init_q || cmd_q == INIT_CMD_LAST);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= '0;
			sub_q   <= '0;
			cmd_q   <= '0;
			init_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						phase_q <= '0;
						sub_q   <= '0;
						cmd_q   <= '0;
						init_q  <= (req_type == REQ_INIT);
						state_q <= (req_type == REQ_INIT) ? ST_PWR : ST_BYTE;
					end
				end
				ST_PWR: begin
					if (emit) state_q <= ST_RST;
				end
				ST_RST: begin
					if (emit) begin
						if (!phase_end) begin
							phase_q <= phase_q + 2'd1;
						end else begin
							phase_q <= '0;
							if (sub_q == RST_NIB_LAST) begin
								sub_q   <= '0;
								state_q <= ST_BYTE;
							end else begin
								sub_q <= sub_q + 2'd1;
							end
						end
					end
				end
				ST_BYTE: begin
					if (emit) begin
						if (!phase_end) begin
							phase_q <= phase_q + 2'd1;
						end else begin
							phase_q <= '0;
							if (!sub_q[0]) begin
								sub_q <= 2'd1;
							end else begin
								sub_q <= '0;
								if (init_q && cmd_q != INIT_CMD_LAST) begin
									cmd_q <= cmd_q + 3'd1;
								end else begin
									state_q <= ST_IDLE;
								end
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/lcdseq_dp.sv
// ----------------------------------------------------------------------------
// lcdseq_dp
// Request latch, pin-state formation and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdseq_dp import lcdseq_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  req_t             req_data,
	input  dp_cmd_t          cmd,
	output dp_status_t       status,
	input  wire logic [7:0]  pulse_us,
	input  wire logic [9:0]  gap_us,
	input  wire logic [15:0] power_us,
	output logic             pin_valid,
	input  wire logic        pin_stall,
	output pin_t             pin_data
);

	logic       rs_q;
	logic [7:0] byte_q;
	logic [6:0] cursor;
	logic [7:0] cur_byte;
	logic       valid_q;
	pin_t       pin_q;
	pin_t       nxt;

	// address = ((line-1)*0x40 + column-1) mod 128
	assign cursor = {~req_data.line[0], 6'd0} + (req_data.column - 7'd1);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			case (req_data.req_type)
				REQ_INIT: begin
					rs_q   <= 1'b0;
					byte_q <= req_data.byte_value;
				end
				REQ_DATA: begin
					rs_q   <= 1'b1;
					byte_q <= req_data.byte_value;
				end
				REQ_CURSOR: begin
					rs_q   <= 1'b0;
					byte_q <= CURSOR_BASE | {1'b0, cursor};
				end
				default: begin
					rs_q   <= 1'b0;
					byte_q <= req_data.byte_value;
				end
			endcase
		end
	end

	assign cur_byte = cmd.init ? init_cmd(cmd.cmd_idx) : byte_q;

	always_comb begin
		nxt.read_write = 1'b0;
		nxt.last       = cmd.last;
		nxt.enable_pin = (cmd.phase == PHASE_HIGH);
		if (cmd.pwr) begin
			nxt.reg_select  = 1'b0;
			nxt.enable_pin  = 1'b0;
			nxt.data_nibble = 4'h0;
			nxt.hold_us     = power_us;
		end else if (cmd.rst) begin
			nxt.reg_select  = 1'b0;
			nxt.data_nibble = init_nibble(cmd.sub);
			nxt.hold_us     = {8'd0, pulse_us} +
				((cmd.phase == PHASE_LAST) ? {3'd0, init_wait(cmd.sub)} : 16'd0);
		end else begin
			nxt.reg_select  = rs_q;
			nxt.data_nibble = cmd.sub[0] ? cur_byte[3:0] : cur_byte[7:4];
			nxt.hold_us     = {8'd0, pulse_us} +
				((cmd.phase == PHASE_LAST && cmd.sub[0]) ? {6'd0, gap_us} : 16'd0);
		end
	end

	assign status.out_free = !valid_q || !pin_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.emit) begin
			valid_q <= 1'b1;
		end else if (!pin_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) pin_q <= nxt;
	end

	assign pin_valid = valid_q;
	assign pin_data  = pin_q;

endmodule

`default_nettype wire

### rtl/char_lcd_nibble_sequencer.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer
// Turns LCD requests into a stream of 4-bit bus pin states with hold times.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_stall | req_data  (req_t)
//  pin     | out       | pin_valid / pin_stall | pin_data  (pin_t)
//  apb     | in        | psel/penable/pwrite   | paddr, pwdata, prdata
//
//  One pin state leaves per cycle while pin_stall is low: a byte request gives
//  6 pin states, init 43; the state machine stepping the phase counters sets
//  this. A new request is taken once the previous one has issued its final
//  pin state. pin_stall freezes a valid output register and the sequencer.
//  Reset loads the default timing registers and empties the output.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_nibble_sequencer import lcdseq_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  req_t                   req_data,
	output logic                   pin_valid,
	input  wire logic              pin_stall,
	output pin_t                   pin_data,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0]      prdata,
	output logic                   pready
);

	logic [7:0]  pulse_q;
	logic [9:0]  gap_q;
	logic [15:0] power_q;
	logic        wr_en;
	dp_cmd_t     cmd;
	dp_status_t  status;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_q <= PULSE_RESET;
			gap_q   <= BYTE_GAP_RESET;
			power_q <= POWER_UP_RESET;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_PULSE:    pulse_q <= pwdata[7:0];
				REG_BYTE_GAP: gap_q   <= pwdata[9:0];
				REG_POWER_UP: power_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_PULSE:    prdata = {24'd0, pulse_q};
			REG_BYTE_GAP: prdata = {22'd0, gap_q};
			REG_POWER_UP: prdata = {16'd0, power_q};
			default:      prdata = '0;
		endcase
	end

	lcdseq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_type  (req_data.req_type),
		.req_stall (req_stall),
		.status    (status),
		.cmd       (cmd)
	);

	lcdseq_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req_data),
		.cmd       (cmd),
		.status    (status),
		.pulse_us  (pulse_q),
		.gap_us    (gap_q),
		.power_us  (power_q),
		.pin_valid (pin_valid),
		.pin_stall (pin_stall),
		.pin_data  (pin_data)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("sequencer not busy after taking a request");

	a_enable_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(pin_valid && pin_data.enable_pin) |-> (pin_data.hold_us == {8'd0, pulse_q}))
		else $error("enable-high state hold differs from pulse phase");

	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.last) |=> !req_stall)
		else $error("sequencer still busy after final pin state");

	a_write_only: assert property (@(posedge clk) disable iff (!arst_n)
		pin_valid |-> !pin_data.read_write)
		else $error("read cycle driven on LCD bus");

endmodule

`default_nettype wire

### bench/tb_char_lcd_nibble_sequencer.sv
// ----------------------------------------------------------------------------
// tb_char_lcd_nibble_sequencer
// Self-checking bench for the 4-bit character LCD pin sequencer. Requests go
// in over a valid/stall channel, and every pin state that comes out is checked
// against a predictor in the bench. The bench first runs a short table of
// directed requests: init, the byte extremes, and cursor positions in range,
// wrapped and out of range. Random requests follow under four timing register
// settings, with random idling on both sides under the first three and one
// pause that lets the output drain. The timing registers are written and read
// back over the APB port.
// ----------------------------------------------------------------------------
module tb_char_lcd_nibble_sequencer import lcdseq_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned LIMIT = 400000;
	localparam logic [39:0] INIT_BYTES = 40'h28_08_01_06_0F;
	localparam logic [15:0] RST_NIBBLES = 16'h3332;
	localparam logic [63:0] RST_WAITS = {16'd5000, 16'd60, 16'd2000, 16'd2000};

	typedef struct packed {
		req_t       rq;
		logic       typed;
		logic       rs;
		logic [7:0] bus_byte;
	} dir_row_t;

	logic              clk;
	logic              arst_n;
	logic              req_valid;
	logic              req_stall;
	req_t              req_data;
	logic              pin_valid;
	logic              pin_stall;
	pin_t              pin_data;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	pin_t        expected_pins[$];
	dir_row_t    dir_rows[$];
	logic [7:0]  cfg_pulse;
	logic [9:0]  cfg_gap;
	logic [15:0] cfg_power;
	int          send_idle_pct;
	int          stall_pct;
	int          fail_cnt;
	int          req_cnt;
	int          init_cnt;
	int          pins_checked;
	int          setting_cnt;
	int unsigned cycles;

	char_lcd_nibble_sequencer dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data(req_data),
		.pin_valid(pin_valid),
		.pin_stall(pin_stall),
		.pin_data(pin_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb: failure");
		$finish;
	end

	// ---------------- pin state predictor ----------------
	function automatic void add_state(input logic rs, input logic en,
			input logic [3:0] nib, input logic [31:0] hold);
		pin_t p;
		p.reg_select  = rs;
		p.read_write  = 1'b0;
		p.enable_pin  = en;
		p.data_nibble = nib;
		p.hold_us     = hold[15:0];
		p.last        = 1'b0;
		expected_pins.push_back(p);
	endfunction

	function automatic void add_nibble(input logic rs, input logic [3:0] nib,
			input logic [31:0] extra);
		add_state(rs, 1'b0, nib, 32'(cfg_pulse));
		add_state(rs, 1'b1, nib, 32'(cfg_pulse));
		add_state(rs, 1'b0, nib, 32'(cfg_pulse) + extra);
	endfunction

	function automatic void add_byte(input logic rs, input logic [7:0] b);
		add_nibble(rs, b[7:4], 32'd0);
		add_nibble(rs, b[3:0], 32'(cfg_gap));
	endfunction

	function automatic void mark_last();
		pin_t p;
		p = expected_pins.pop_back();
		p.last = 1'b1;
		expected_pins.push_back(p);
	endfunction

	function automatic void predict_pins(input req_t r);
		logic [31:0] addr;
		case (r.req_type)
			REQ_INIT: begin
				add_state(1'b0, 1'b0, 4'h0, 32'(cfg_power));
				for (int i = 0; i < 4; i++)
					add_nibble(1'b0, RST_NIBBLES[15-4*i -: 4],
						32'(RST_WAITS[63-16*i -: 16]));
				for (int i = 0; i < 5; i++)
					add_byte(1'b0, INIT_BYTES[39-8*i -: 8]);
			end
			REQ_CMD:  add_byte(1'b0, r.byte_value);
			REQ_DATA: add_byte(1'b1, r.byte_value);
			default: begin
				addr = (32'(r.line) - 32'd1) * 32'h40 + (32'(r.column) - 32'd1);
				add_byte(1'b0, CURSOR_BASE + {1'b0, addr[6:0]});
			end
		endcase
		mark_last();
	endfunction

	// ---------------- result checking ----------------
	task automatic note_mismatch(input string what, input pin_t want, input pin_t got);
		fail_cnt++;
		if (fail_cnt <= 10)
			$display({"%s: exp rs=%0d rw=%0d e=%0d d=%h hold=%0d last=%0d",
				" | got rs=%0d rw=%0d e=%0d d=%h hold=%0d last=%0d"},
				what, want.reg_select, want.read_write, want.enable_pin, want.data_nibble,
				want.hold_us, want.last, got.reg_select, got.read_write, got.enable_pin,
				got.data_nibble, got.hold_us, got.last);
	endtask

	initial begin : pin_side
		pin_t want;
		pin_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && pin_valid && !pin_stall) begin
				pins_checked++;
				if (expected_pins.size() == 0) begin
					note_mismatch("pin state with none pending", '0, pin_data);
				end else begin
					want = expected_pins.pop_front();
					if (pin_data.reg_select !== want.reg_select
							|| pin_data.read_write !== want.read_write
							|| pin_data.enable_pin !== want.enable_pin
							|| pin_data.data_nibble !== want.data_nibble
							|| pin_data.hold_us !== want.hold_us
							|| pin_data.last !== want.last)
						note_mismatch("pin state mismatch", want, pin_data);
				end
			end
			pin_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
		end
	end

	// ---------------- request side ----------------
	task automatic send_req(input req_t r, input logic typed, input logic rs,
			input logic [7:0] bus_byte);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= r;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		if (typed) begin
			add_byte(rs, bus_byte);
			mark_last();
		end else begin
			predict_pins(r);
		end
		req_cnt++;
		if (r.req_type == REQ_INIT)
			init_cnt++;
	endtask

	function automatic req_t rand_req();
		req_t r;
		int unsigned k;
		k = $urandom_range(99);
		r.byte_value = 8'($urandom);
		r.line = 2'($urandom);
		r.column = 7'($urandom);
		if (k < 4)
			r.req_type = REQ_INIT;
		else if (k < 36)
			r.req_type = REQ_CMD;
		else if (k < 68)
			r.req_type = REQ_DATA;
		else begin
			r.req_type = REQ_CURSOR;
			if ($urandom_range(99) < 80) begin
				r.line = 2'($urandom_range(1, 2));
				r.column = 7'($urandom_range(1, 64));
			end
		end
		return r;
	endfunction

	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (expected_pins.size() != 0) @(posedge clk);
	endtask

	task automatic run_random(input int n, input int pause_at);
		for (int i = 0; i < n; i++) begin
			if (i == pause_at)
				drain();
			send_req(rand_req(), 1'b0, 1'b0, 8'h00);
		end
	endtask

	// ---------------- APB ----------------
	task automatic cfg_write(input reg_idx_t idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic cfg_read(input reg_idx_t idx, output logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_W'({idx, 2'b00});
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		val = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic cfg_check();
		logic [31:0] v;
		cfg_read(REG_PULSE, v);
		if (v[7:0] !== cfg_pulse) begin
			fail_cnt++;
			if (fail_cnt <= 10)
				$display("pulse_phase_us readback: exp %0d got %0d", cfg_pulse, v[7:0]);
		end
		cfg_read(REG_BYTE_GAP, v);
		if (v[9:0] !== cfg_gap) begin
			fail_cnt++;
			if (fail_cnt <= 10)
				$display("byte_gap_us readback: exp %0d got %0d", cfg_gap, v[9:0]);
		end
		cfg_read(REG_POWER_UP, v);
		if (v[15:0] !== cfg_power) begin
			fail_cnt++;
			if (fail_cnt <= 10)
				$display("power_up_us readback: exp %0d got %0d", cfg_power, v[15:0]);
		end
	endtask

	task automatic cfg_apply(input logic [7:0] pulse, input logic [9:0] gap,
			input logic [15:0] power);
		drain();
		repeat (8) @(posedge clk);
		cfg_write(REG_PULSE, 32'(pulse));
		cfg_write(REG_BYTE_GAP, 32'(gap));
		cfg_write(REG_POWER_UP, 32'(power));
		cfg_pulse = pulse;
		cfg_gap = gap;
		cfg_power = power;
		setting_cnt++;
		cfg_check();
	endtask

	task automatic dir_row(input req_kind_t k, input logic [7:0] b, input logic [1:0] ln,
			input logic [6:0] col, input logic typed, input logic rs,
			input logic [7:0] bus_byte);
		dir_row_t d;
		d.rq.req_type = k;
		d.rq.byte_value = b;
		d.rq.line = ln;
		d.rq.column = col;
		d.typed = typed;
		d.rs = rs;
		d.bus_byte = bus_byte;
		dir_rows.push_back(d);
	endtask

	// ---------------- main sequence ----------------
	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		send_idle_pct = 32;
		stall_pct = 48;
		fail_cnt = 0;
		req_cnt = 0;
		init_cnt = 0;
		pins_checked = 0;
		setting_cnt = 1;
		cfg_pulse = PULSE_RESET;
		cfg_gap = BYTE_GAP_RESET;
		cfg_power = POWER_UP_RESET;

		dir_row(REQ_INIT,   8'h00, 2'd0, 7'd0,   1'b0, 1'b0, 8'h00);
		dir_row(REQ_CMD,    8'h00, 2'd1, 7'd1,   1'b1, 1'b0, 8'h00);
		dir_row(REQ_CMD,    8'hFF, 2'd3, 7'd127, 1'b1, 1'b0, 8'hFF);
		dir_row(REQ_DATA,   8'h00, 2'd0, 7'd0,   1'b1, 1'b1, 8'h00);
		dir_row(REQ_DATA,   8'hFF, 2'd2, 7'd64,  1'b1, 1'b1, 8'hFF);
		dir_row(REQ_DATA,   8'hA5, 2'd1, 7'd5,   1'b1, 1'b1, 8'hA5);
		dir_row(REQ_CMD,    8'h5A, 2'd2, 7'd9,   1'b1, 1'b0, 8'h5A);
		dir_row(REQ_CURSOR, 8'h00, 2'd1, 7'd1,   1'b1, 1'b0, 8'h80);
		dir_row(REQ_CURSOR, 8'hFF, 2'd2, 7'd1,   1'b1, 1'b0, 8'hC0);
		dir_row(REQ_CURSOR, 8'h00, 2'd1, 7'd64,  1'b1, 1'b0, 8'hBF);
		dir_row(REQ_CURSOR, 8'h3C, 2'd2, 7'd64,  1'b1, 1'b0, 8'hFF);
		// out-of-range line or column wraps to 7 bits
		dir_row(REQ_CURSOR, 8'h00, 2'd0, 7'd0,   1'b1, 1'b0, 8'hBF);
		dir_row(REQ_CURSOR, 8'h00, 2'd0, 7'd1,   1'b1, 1'b0, 8'hC0);
		dir_row(REQ_CURSOR, 8'h00, 2'd3, 7'd127, 1'b1, 1'b0, 8'hFE);
		dir_row(REQ_CURSOR, 8'h00, 2'd1, 7'd0,   1'b1, 1'b0, 8'hFF);
		dir_row(REQ_CURSOR, 8'h00, 2'd2, 7'd65,  1'b1, 1'b0, 8'h80);
		dir_row(REQ_INIT,   8'hFF, 2'd3, 7'd127, 1'b0, 1'b0, 8'h00);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		cfg_check();

		foreach (dir_rows[i])
			send_req(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].rs,
				dir_rows[i].bus_byte);
		run_random(30, -1);

		cfg_apply(8'd0, 10'd0, 16'd0);
		run_random(30, -1);

		send_idle_pct = 48;
		stall_pct = 32;
		cfg_apply(8'd255, 10'd1023, 16'd65535);
		run_random(45, 20);

		send_idle_pct = 0;
		stall_pct = 0;
		cfg_apply(8'd1, 10'($urandom_range(0, 1023)), 16'($urandom));
		run_random(45, -1);

		drain();
		repeat (20) @(posedge clk);

		$display("covered %0d requests (%0d init) under %0d timing settings, %0d pin states",
			req_cnt, init_cnt, setting_cnt, pins_checked);
		$display("mismatches: %0d", fail_cnt);
		if (fail_cnt == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
